/* rtl/core/mrs_pkg.sv */
// Shared constants and types for the Modbus RTU register slave.
// No dependencies.
`timescale 1ns / 1ps
package mrs_pkg;
    localparam int RegWords      = 32;
    localparam int FrameCapacity = 64;
    localparam int RegAw         = $clog2(RegWords);
    localparam int CntW          = $clog2(FrameCapacity + 1);
    localparam int ReadMaxWords  = 29;

    localparam logic [1:0]  REQ_BYTE   = 2'd0;
    localparam logic [1:0]  REQ_GAP    = 2'd1;
    localparam logic [1:0]  REQ_SENSOR = 2'd2;
    localparam logic [7:0]  FC_READ    = 8'h03;
    localparam logic [7:0]  FC_WRITE   = 8'h06;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [15:0] ADDR_MOIST = 16'h0011;
    localparam logic [15:0] ADDR_TEMP  = 16'h0012;

    // transmit byte source
    typedef enum logic [2:0] {
        SRC_ADDR, SRC_FC, SRC_BCNT, SRC_HI, SRC_LO, SRC_CRCL, SRC_CRCH, SRC_HEAD
    } src_t;

    typedef struct packed {
        logic       rx_push;    // store rx byte
        logic       clr_frame;  // frame consumed
        logic       sensor;     // load sensor words
        logic       wr_word;    // store written word
        logic       rd_issue;   // read register at rd_idx
        logic       emit;       // load output register
        src_t       src;
        logic [2:0] head_sel;
        logic       last;
        logic       crc_init;   // reset tx crc
    } cmd_t;

    typedef struct packed {
        logic       frame_ok;   // >= 8 bytes, address and crc good
        logic       long_enough;
        logic       is_read;
        logic       is_write;
        logic       read_ok;
        logic       write_ok;
        logic [4:0] words;      // capped read count
    } sts_t;

    function automatic logic [15:0] crc_fold(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        return x;
    endfunction
endpackage

/* rtl/core/mrs_ram.sv */
// Generic RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module mrs_ram #(
    parameter int Width = 16,
    parameter int Depth = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

/* rtl/core/mrs_datapath.sv */
// Datapath: frame buffer, receive CRC, register file, response byte builder.
// Depends on mrs_pkg and mrs_ram.
`timescale 1ns / 1ps
module mrs_datapath
    import mrs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    output sts_t       sts,
    input  logic [7:0] slave_address,
    input  logic [7:0] rx_byte,
    input  logic [15:0] moisture_value,
    input  logic [15:0] temperature_value,
    output logic [7:0] tx_byte,
    output logic       last_byte
);
    logic [7:0]      head_reg [8];
    logic [7:0]      tail0_reg, tail1_reg;
    logic [CntW-1:0] cnt_reg;
    logic [15:0]     crc_reg, txcrc_reg;
    logic [15:0]     moist_reg, temp_reg;
    logic [RegAw-1:0] rd_idx_reg;
    logic [15:0]     ram_q;
    logic [7:0]      tx_byte_reg;
    logic            last_reg;
    logic [15:0]     addr16, val16, cnt16;
    logic [16:0]     sum17;
    logic            is_moist_q, is_temp_q;
    logic [15:0]     rd_word;
    logic [7:0]      byte_sel;

    assign addr16 = {head_reg[2], head_reg[3]};
    assign cnt16  = {head_reg[4], head_reg[5]};
    assign val16  = cnt16;
    assign sum17  = {1'b0, addr16} + {1'b0, cnt16};

    assign sts.long_enough = (cnt_reg >= CntW'(8));
    assign sts.frame_ok = sts.long_enough && (head_reg[0] == slave_address)
                          && ({tail1_reg, tail0_reg} == crc_reg);
    assign sts.is_read  = (head_reg[1] == FC_READ);
    assign sts.is_write = (head_reg[1] == FC_WRITE);
    assign sts.read_ok  = (sum17 <= 17'(RegWords));
    assign sts.write_ok = (addr16 != ADDR_MOIST) && (addr16 != ADDR_TEMP)
                          && (addr16 < 16'(RegWords));
    assign sts.words = (cnt16 > 16'(ReadMaxWords)) ? 5'(ReadMaxWords) : cnt16[4:0];

    // sensor words live in flops; the RAM copy of those two is never read
    mrs_ram #(.Width(16), .Depth(RegWords)) u_ram (
        .clk  (clk),
        .we   (cmd.wr_word),
        .waddr(addr16[RegAw-1:0]),
        .wdata(val16),
        .raddr(rd_idx_reg),
        .rdata(ram_q)
    );

    logic [RegAw-1:0] rd_addr_q;
    always_ff @(posedge clk)
    begin
        if (cmd.rd_issue)
            rd_addr_q <= rd_idx_reg;
    end
    assign is_moist_q = (rd_addr_q == RegAw'(ADDR_MOIST));
    assign is_temp_q  = (rd_addr_q == RegAw'(ADDR_TEMP));

    // words never written hold reset value: tracked per word
    logic [RegWords-1:0] written_reg;
    logic [15:0] reset_word;
    always_comb
    begin
        reset_word = 16'd0;
        if (rd_addr_q == RegAw'(0) || rd_addr_q == RegAw'(16'h10))
            reset_word = 16'd1;
    end
    assign rd_word = is_moist_q ? moist_reg : is_temp_q ? temp_reg :
                     written_reg[rd_addr_q] ? ram_q : reset_word;

    always_comb
    begin
        case (cmd.src)
            SRC_ADDR: byte_sel = slave_address;
            SRC_FC:   byte_sel = FC_READ;
            SRC_BCNT: byte_sel = {2'b00, sts.words, 1'b0};
            SRC_HI:   byte_sel = rd_word[15:8];
            SRC_LO:   byte_sel = rd_word[7:0];
            SRC_CRCL: byte_sel = txcrc_reg[7:0];
            SRC_CRCH: byte_sel = txcrc_reg[15:8];
            SRC_HEAD: byte_sel = head_reg[cmd.head_sel];
            default:  byte_sel = 8'h00;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            crc_reg     <= CRC_INIT;
            moist_reg   <= 16'd128;
            temp_reg    <= 16'd253;
            written_reg <= '0;
            rd_idx_reg  <= '0;
        end
        else
        begin
            if (cmd.rx_push && cnt_reg < CntW'(FrameCapacity))
            begin
                if (cnt_reg >= CntW'(2))
                    crc_reg <= crc_fold(crc_reg, tail0_reg);
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.clr_frame)
            begin
                cnt_reg <= '0;
                crc_reg <= CRC_INIT;
            end
            if (cmd.sensor)
            begin
                moist_reg <= moisture_value;
                temp_reg  <= temperature_value;
            end
            if (cmd.wr_word)
                written_reg[addr16[RegAw-1:0]] <= 1'b1;
            // read address held until the low byte of the word has gone out
            if (cmd.crc_init)
                rd_idx_reg <= addr16[RegAw-1:0];
            else if (cmd.emit && cmd.src == SRC_LO)
                rd_idx_reg <= rd_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rx_push && cnt_reg < CntW'(FrameCapacity))
        begin
            if (cnt_reg < CntW'(8))
                head_reg[cnt_reg[2:0]] <= rx_byte;
            tail0_reg <= tail1_reg;
            tail1_reg <= rx_byte;
        end
        // CRC bytes themselves are not folded in
        if (cmd.crc_init)
            txcrc_reg <= CRC_INIT;
        else if (cmd.emit && cmd.src != SRC_CRCL && cmd.src != SRC_CRCH)
            txcrc_reg <= crc_fold(txcrc_reg, byte_sel);
        if (cmd.emit)
        begin
            tx_byte_reg <= byte_sel;
            last_reg    <= cmd.last;
        end
    end

    assign tx_byte   = tx_byte_reg;
    assign last_byte = last_reg;
endmodule

/* rtl/core/mrs_ctrl.sv */
// Controller: accepts items, sequences frame check and response bytes.
// Depends on mrs_pkg.
`timescale 1ns / 1ps
module mrs_ctrl
    import mrs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] req_type,
    output logic       out_valid,
    input  logic       out_stall,
    output cmd_t       cmd,
    input  sts_t       sts
);
    typedef enum logic [2:0] {
        S_IDLE, S_RHDR, S_RREQ, S_RHI, S_RLO, S_CRCL, S_CRCH, S_ECHO
    } state_t;

    state_t     state_reg;
    logic [4:0] left_reg;
    logic [2:0] k_reg;
    logic       ovalid_reg;
    logic [1:0] hdr_reg;

    logic take, slot;
    assign take = in_valid && !in_stall;
    assign slot = !ovalid_reg || !out_stall;   // output register free this edge
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ovalid_reg;

    always_comb
    begin
        cmd = '0;
        cmd.rx_push = take && (req_type == REQ_BYTE);
        cmd.sensor  = take && (req_type == REQ_SENSOR);
        if (take && req_type == REQ_GAP && sts.long_enough)
        begin
            cmd.clr_frame = 1'b1;
            cmd.crc_init  = 1'b1;
            cmd.wr_word   = sts.frame_ok && sts.is_write && sts.write_ok;
        end
        case (state_reg)
            S_RHDR:
            begin
                cmd.emit = slot;
                cmd.src  = (hdr_reg == 2'd0) ? SRC_ADDR : (hdr_reg == 2'd1) ? SRC_FC : SRC_BCNT;
            end
            S_RREQ: cmd.rd_issue = 1'b1;
            S_RHI:  begin cmd.emit = slot; cmd.src = SRC_HI; end
            S_RLO:  begin cmd.emit = slot; cmd.src = SRC_LO; end
            S_CRCL: begin cmd.emit = slot; cmd.src = SRC_CRCL; end
            S_CRCH: begin cmd.emit = slot; cmd.src = SRC_CRCH; cmd.last = 1'b1; end
            S_ECHO:
            begin
                cmd.emit = slot;
                cmd.src = SRC_HEAD;
                cmd.head_sel = k_reg;
                cmd.last = (k_reg == 3'd7);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            left_reg   <= '0;
            k_reg      <= '0;
            hdr_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
                ovalid_reg <= 1'b1;
            else if (!out_stall)
                ovalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (take && req_type == REQ_GAP && sts.frame_ok)
                    begin
                        if (sts.is_read && sts.read_ok)
                        begin
                            state_reg <= S_RHDR;
                            hdr_reg   <= '0;
                            left_reg  <= sts.words;
                        end
                        else if (sts.is_write && sts.write_ok)
                        begin
                            state_reg <= S_ECHO;
                            k_reg     <= '0;
                        end
                    end
                end
                S_RHDR:
                    if (slot)
                    begin
                        hdr_reg <= hdr_reg + 1'b1;
                        if (hdr_reg == 2'd2)
                            state_reg <= (left_reg == 5'd0) ? S_CRCL : S_RREQ;
                    end
                S_RREQ: state_reg <= S_RHI;
                S_RHI:  if (slot) state_reg <= S_RLO;
                S_RLO:
                    if (slot)
                    begin
                        left_reg  <= left_reg - 1'b1;
                        state_reg <= (left_reg == 5'd1) ? S_CRCL : S_RREQ;
                    end
                S_CRCL: if (slot) state_reg <= S_CRCH;
                S_CRCH: if (slot) state_reg <= S_IDLE;
                S_ECHO:
                    if (slot)
                    begin
                        k_reg <= k_reg + 1'b1;
                        if (k_reg == 3'd7)
                            state_reg <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !take) else $error("item taken while busy");
    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> slot) else $error("output overwritten");
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.last) |=> (state_reg == S_IDLE)) else $error("last not final");
endmodule

/* rtl/core/modbus_rtu_register_slave_unit.sv */
// Top level of the Modbus RTU register slave (function codes 03 and 06).
// Depends on mrs_pkg, mrs_ctrl, mrs_datapath, mrs_ram.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid/in_stall) carries one item per beat: a received
//   byte, a frame gap, or a sensor update. Output channel (out_valid/
//   out_stall) carries one response byte per beat, last_byte marking the end.
//   Byte, sensor and unanswered gap items are taken at once. An answered
//   gap keeps the input stalled: a write echo while the eight request bytes
//   go out, a read while the header bytes, per word a RAM read (registered
//   read port) and the two data bytes, and the two CRC bytes go out.
//   in_stall is high while a response is being sent; items wait.
//   A stalled receiver holds the output register and the sequencer pauses.
//   Reset clears the frame, restores the register file defaults and sets the
//   station address to 1. slave_address_we writes the station address.
//   Register file words read by the response come from a two-port RAM;
//   per-word written flags give the reset contents without a clearing pass.
module modbus_rtu_register_slave_unit
    import mrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        slave_address_we,
    input  logic [7:0]  slave_address_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [7:0]  rx_byte,
    input  logic signed [15:0] moisture_value,
    input  logic signed [15:0] temperature_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  tx_byte,
    output logic        last_byte
);
    logic [7:0] addr_reg;
    cmd_t cmd;
    sts_t sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            addr_reg <= 8'd1;
        else if (slave_address_we)
            addr_reg <= slave_address_wdata;
    end

    mrs_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .out_valid(out_valid), .out_stall(out_stall),
        .cmd(cmd), .sts(sts)
    );

    mrs_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .slave_address(addr_reg),
        .rx_byte(rx_byte), .moisture_value(moisture_value),
        .temperature_value(temperature_value), .tx_byte(tx_byte), .last_byte(last_byte)
    );
endmodule

/* tb/tb_modbus_rtu_register_slave_unit.sv */
// Self-checking bench for the Modbus RTU register slave: frames, gaps, sensor loads.
// Depends on mrs_pkg and modbus_rtu_register_slave_unit.
`timescale 1ns / 1ps
module tb_modbus_rtu_register_slave_unit
    import mrs_pkg::*;
();

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [15:0] moist;
        logic [15:0] temp;
    } beat_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } resp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic sa_we = 1'b0;
    logic [7:0] sa_wdata = 8'd0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] req_type = 2'd0;
    logic [7:0] rx_byte = 8'd0;
    logic signed [15:0] moisture_value = 16'sd0;
    logic signed [15:0] temperature_value = 16'sd0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [7:0] tx_byte;
    logic last_byte;

    beat_t pending_q[$];
    resp_t expected_q[$];
    int    failures = 0;
    bit    hold_off = 1'b0;   // long receiver hold-off request
    int    beats_sent = 0;

    // predictor state
    logic [15:0] regs[RegWords];
    logic [7:0]  head[8];
    logic [7:0]  tail[2];
    int          fill;
    logic [15:0] crc_acc;
    logic [7:0]  station;

    always #6 clk = ~clk;

    modbus_rtu_register_slave_unit i_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .slave_address_we    (sa_we),
        .slave_address_wdata (sa_wdata),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .req_type            (req_type),
        .rx_byte             (rx_byte),
        .moisture_value      (moisture_value),
        .temperature_value   (temperature_value),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .tx_byte             (tx_byte),
        .last_byte           (last_byte)
    );

    function automatic logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
        logic [15:0] x;
        x = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
            x = x[0] ? ((x >> 1) ^ 16'hA001) : (x >> 1);
        return x;
    endfunction

    task automatic push_resp(logic [7:0] b, logic l, inout logic [15:0] c);
        resp_t r;
        r.data = b;
        r.last = l;
        expected_q.push_back(r);
        c = crc16_step(c, b);
    endtask

    task automatic slave_predict(beat_t it);
        logic [15:0] got, c, v;
        int addr, cnt;
        c = 16'hFFFF;
        if (it.kind == REQ_BYTE)
        begin
            if (fill < FrameCapacity)
            begin
                if (fill < 8)
                    head[fill] = it.data;
                if (fill >= 2)
                    crc_acc = crc16_step(crc_acc, tail[0]);
                tail[0] = tail[1];
                tail[1] = it.data;
                fill++;
            end
        end
        else if (it.kind == REQ_GAP)
        begin
            if (fill >= 8)
            begin
                got = {tail[1], tail[0]};
                addr = {head[2], head[3]};
                if (head[0] == station && got == crc_acc)
                begin
                    if (head[1] == FC_READ)
                    begin
                        cnt = {head[4], head[5]};
                        if (addr + cnt <= RegWords)
                        begin
                            if (cnt > ReadMaxWords)
                                cnt = ReadMaxWords;
                            push_resp(station, 1'b0, c);
                            push_resp(FC_READ, 1'b0, c);
                            push_resp(8'(cnt * 2), 1'b0, c);
                            for (int i = 0; i < cnt; i++)
                            begin
                                v = regs[(addr + i) % RegWords];
                                push_resp(v[15:8], 1'b0, c);
                                push_resp(v[7:0], 1'b0, c);
                            end
                            v = c;
                            push_resp(v[7:0], 1'b0, c);
                            push_resp(v[15:8], 1'b1, c);
                        end
                    end
                    else if (head[1] == FC_WRITE)
                    begin
                        if (addr != ADDR_MOIST && addr != ADDR_TEMP && addr < RegWords)
                        begin
                            regs[addr] = {head[4], head[5]};
                            for (int k = 0; k < 8; k++)
                                push_resp(head[k], k == 7, c);
                        end
                    end
                end
                fill = 0;
                crc_acc = 16'hFFFF;
            end
        end
        else if (it.kind == REQ_SENSOR)
        begin
            regs[ADDR_MOIST] = it.moist;
            regs[ADDR_TEMP] = it.temp;
        end
    endtask

    // stimulus helpers
    task automatic add_beat(logic [1:0] k, logic [7:0] d, logic [15:0] m, logic [15:0] t);
        beat_t b;
        b.kind = k;
        b.data = d;
        b.moist = m;
        b.temp = t;
        pending_q.push_back(b);
    endtask

    // whole frame: given 6 body bytes, a good or bad CRC, optional extra payload
    task automatic add_frame(logic [7:0] a, logic [7:0] fc, logic [15:0] p, logic [15:0] q,
                             bit bad_crc, int extra);
        logic [7:0]  body[$];
        logic [15:0] c;
        body = '{a, fc, p[15:8], p[7:0], q[15:8], q[7:0]};
        for (int i = 0; i < extra; i++)
            body.push_back(8'($urandom));
        c = 16'hFFFF;
        foreach (body[i])
        begin
            c = crc16_step(c, body[i]);
            add_beat(REQ_BYTE, body[i], 16'($urandom), 16'($urandom));
        end
        if (bad_crc)
            c ^= 16'(1 << $urandom_range(15, 0));
        add_beat(REQ_BYTE, c[7:0], 16'($urandom), 16'($urandom));
        add_beat(REQ_BYTE, c[15:8], 16'($urandom), 16'($urandom));
        add_beat(REQ_GAP, 8'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0)
            @(posedge clk);
        while (in_valid || expected_q.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic set_station(logic [7:0] a);
        @(posedge clk);
        sa_we <= 1'b1;
        sa_wdata <= a;
        @(posedge clk);
        sa_we <= 1'b0;
        station = a;
    endtask

    // driver: one beat per handshake, random idle before each
    always @(posedge clk)
    begin
        int gap;
        beat_t b;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                beats_sent++;
            if ((!in_valid || !in_stall) && pending_q.size() != 0)
            begin
                gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 0);
                if ($urandom_range(1, 0) == 0)
                    gap = 0;
                if (gap != 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                b = pending_q.pop_front();
                slave_predict(b);
                req_type <= b.kind;
                rx_byte <= b.data;
                moisture_value <= b.moist;
                temperature_value <= b.temp;
                in_valid <= 1'b1;
            end
            else if (in_valid && !in_stall)
                in_valid <= 1'b0;
        end
    end

    // monitor: checks each accepted response byte
    always @(posedge clk)
    begin
        resp_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected response byte tx_byte %h", tx_byte);
                failures++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (tx_byte !== e.data)
                begin
                    $error("tx_byte expected %h got %h", e.data, tx_byte);
                    failures++;
                end
                if (last_byte !== e.last)
                begin
                    $error("last_byte expected %b got %b", e.last, last_byte);
                    failures++;
                end
            end
        end
    end

    // receiver stall: random per beat, long hold-off on request
    always @(posedge clk)
    begin
        int n;
        if (rst_n)
        begin
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
                out_stall <= 1'b0;
            end
            else
            begin
                n = ($urandom_range(2, 0) == 0) ? $urandom_range(12, 0) : 0;
                if (n != 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
                out_stall <= 1'b0;
            end
        end
    end

    task automatic random_part(int items);
        int start, r;
        logic [15:0] p, q;
        start = pending_q.size() + beats_sent;
        while (pending_q.size() + beats_sent - start < items)
        begin
            r = $urandom_range(19, 0);
            p = $urandom_range(1, 0) ? 16'($urandom_range(35, 0)) : 16'($urandom);
            q = $urandom_range(1, 0) ? 16'($urandom_range(12, 0)) : 16'($urandom);
            if (r < 7)
                add_frame(station, FC_READ, p, q, 1'b0, 0);
            else if (r < 12)
                add_frame(station, FC_WRITE, p, q, 1'b0, 0);
            else if (r == 12)
                add_frame(station, FC_READ, p, q, 1'b1, $urandom_range(3, 0));
            else if (r == 13)
                add_frame(8'($urandom), 8'($urandom), p, q, 1'b0, $urandom_range(60, 0));
            else if (r == 14)
                add_beat(REQ_SENSOR, 8'($urandom), 16'($urandom), 16'($urandom));
            else if (r == 15)
                add_beat(2'd3, 8'($urandom), 16'($urandom), 16'($urandom));
            else if (r == 16)
                add_beat(REQ_GAP, 8'($urandom), 16'($urandom), 16'($urandom));
            else
                add_beat(REQ_BYTE, 8'($urandom), 16'($urandom), 16'($urandom));
        end
    endtask

    initial
    begin
        for (int i = 0; i < RegWords; i++)
            regs[i] = 16'd0;
        regs[0] = 16'd1;
        regs[16'h10] = 16'd1;
        regs[ADDR_MOIST] = 16'd128;
        regs[ADDR_TEMP] = 16'd253;
        fill = 0;
        crc_acc = 16'hFFFF;
        station = 8'd1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset contents, cap, range, refused words, short frame kept
        add_frame(8'd1, FC_READ, 16'd0, 16'd32, 1'b0, 0);
        add_frame(8'd1, FC_READ, 16'd0, 16'd19, 1'b0, 0);
        add_frame(8'd1, FC_READ, 16'd31, 16'd1, 1'b0, 0);
        add_frame(8'd1, FC_READ, 16'd1, 16'd32, 1'b0, 0);
        add_frame(8'd1, FC_WRITE, ADDR_MOIST, 16'hFFFF, 1'b0, 0);
        add_frame(8'd1, FC_WRITE, 16'd32, 16'h1234, 1'b0, 0);
        add_frame(8'd1, FC_WRITE, 16'd31, 16'h8000, 1'b0, 0);
        add_frame(8'd1, 8'h10, 16'd0, 16'd1, 1'b0, 0);
        add_frame(8'd2, FC_READ, 16'd0, 16'd1, 1'b0, 0);
        add_frame(8'd1, FC_READ, 16'd0, 16'd1, 1'b1, 0);
        add_beat(REQ_SENSOR, 8'd0, 16'h8000, 16'h7FFF);
        add_beat(REQ_BYTE, 8'd1, 16'd0, 16'd0);
        add_beat(REQ_GAP, 8'd0, 16'd0, 16'd0);        // short fragment stays
        add_beat(2'd3, 8'hFF, 16'hFFFF, 16'hFFFF);
        add_beat(REQ_GAP, 8'd0, 16'd0, 16'd0);        // 1 byte + next frame -> junk
        add_frame(8'd1, FC_READ, 16'h10, 16'd3, 1'b0, 0);
        add_frame(8'd1, FC_READ, 16'h10, 16'd3, 1'b0, 0);
        add_frame(8'd1, FC_READ, 16'd0, 16'd1, 1'b0, 70); // overfull frame
        wait_drained();

        // long receiver hold-off while the sender keeps going
        hold_off = 1'b1;
        for (int i = 0; i < 6; i++)
            add_frame(station, FC_READ, 16'd0, 16'd29, 1'b0, 0);
        wait_drained();

        set_station(8'd0);
        random_part(70);
        wait_drained();
        set_station(8'd255);
        random_part(70);
        wait_drained();
        set_station(8'($urandom));
        random_part(70);
        wait_drained();

        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
